/* rtl/core/gfare_pkg.sv */
// ============================================================================
// gfare_pkg
// Shared widths and defaults for the gap-filtered acknowledgement rate
// estimator.
// ============================================================================
package gfare_pkg;

    // Field widths of the acknowledgement and rate channels.
    localparam int TIME_W  = 64;
    localparam int BYTES_W = 32;
    localparam int RTT_W   = 40;
    localparam int RATE_W  = 64;

    // Default configuration of the estimator.
    localparam int HISTORY_DEPTH_DEF    = 5;
    localparam int TICKS_PER_SECOND_DEF = 1000000000;

endpackage

/* rtl/core/gfare_if.sv */
// ============================================================================
// gfare_if
// Valid/ready channels that carry acknowledgement events into the estimator
// and rate reports out of it.
// ============================================================================

// Acknowledgement event channel.
interface gfare_ack_if;
    import gfare_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_W-1:0]    ack_time;
    logic [BYTES_W-1:0]   acked_bytes;
    logic [RTT_W-1:0]     srtt;

    modport source (output valid, ack_time, acked_bytes, srtt, input ready);
    modport sink   (input valid, ack_time, acked_bytes, srtt, output ready);
endinterface

// Rate report channel.
interface gfare_rate_if;
    import gfare_pkg::*;

    logic                valid;
    logic                ready;
    logic [RATE_W-1:0]   rate_max;
    logic [RATE_W-1:0]   latest_rate;
    logic                window_closed;

    modport source (output valid, rate_max, latest_rate, window_closed, input ready);
    modport sink   (input valid, rate_max, latest_rate, window_closed, output ready);
endinterface

/* rtl/core/gfare_muldiv.sv */
// ============================================================================
// gfare_muldiv
// Iterative unit that forms a * TICKS_PER_SECOND at full width with one
// shared 32-bit multiplier, then divides by d one quotient bit per cycle.
// A quotient that does not fit in 64 bits saturates to all ones.
// ============================================================================
module gfare_muldiv #(
    parameter int TICKS_PER_SECOND = gfare_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gfare_pkg::RATE_W-1:0] a,
    input  logic [gfare_pkg::RATE_W-1:0] d,
    output logic                        done,
    output logic [gfare_pkg::RATE_W-1:0] q
);
    import gfare_pkg::*;

    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int HALF_W = RATE_W / 2;
    localparam int MUL_W  = HALF_W + TPS_W;
    localparam int PROD_W = RATE_W + TPS_W;
    localparam int CNT_W  = $clog2(RATE_W);
    localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);

    typedef enum logic [6:0] {
        MD_IDLE = 7'b0000001,
        MD_MLO  = 7'b0000010,
        MD_MHI  = 7'b0000100,
        MD_SUM  = 7'b0001000,
        MD_CHK  = 7'b0010000,
        MD_DIV  = 7'b0100000,
        MD_DONE = 7'b1000000
    } md_state_t;

    md_state_t            state_reg, state_next;
    logic [RATE_W-1:0]    a_reg, a_next;
    logic [RATE_W-1:0]    d_reg, d_next;
    logic [MUL_W-1:0]     plo_reg, plo_next;
    logic [MUL_W-1:0]     phi_reg, phi_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [RATE_W-1:0]    lo_reg, lo_next;
    logic [RATE_W-1:0]    q_reg, q_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [HALF_W-1:0]    mul_in;
    logic [MUL_W-1:0]     mul_out;
    logic [PROD_W-1:0]    prod;
    logic [RATE_W:0]      div_trial;
    logic                 div_ge;
    logic [RATE_W:0]      div_diff;

    // Shared multiplier: low half of a, then high half of a.
    assign mul_in  = (state_reg == MD_MLO) ? a_reg[HALF_W-1:0] : a_reg[RATE_W-1:HALF_W];
    assign mul_out = MUL_W'(mul_in) * MUL_W'(TPS_C);

    // Recombine the two partial products.
    assign prod = {phi_reg, {HALF_W{1'b0}}} + PROD_W'(plo_reg);

    // One restoring division step on the shifted remainder.
    assign div_trial = {rem_reg, lo_reg[RATE_W-1]};
    assign div_ge    = div_trial >= {1'b0, d_reg};
    assign div_diff  = div_trial - {1'b0, d_reg};

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        d_next     = d_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    d_next     = d;
                    state_next = MD_MLO;
                end
            end
            MD_MLO:
            begin
                plo_next   = mul_out;
                state_next = MD_MHI;
            end
            MD_MHI:
            begin
                phi_next   = mul_out;
                state_next = MD_SUM;
            end
            MD_SUM:
            begin
                rem_next   = RATE_W'(prod[PROD_W-1:RATE_W]);
                lo_next    = prod[RATE_W-1:0];
                state_next = MD_CHK;
            end
            MD_CHK:
            begin
                // The high word already reaching the divisor means overflow.
                if (rem_reg >= d_reg)
                begin
                    q_next     = '1;
                    state_next = MD_DONE;
                end
                else
                begin
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next = div_ge ? div_diff[RATE_W-1:0] : div_trial[RATE_W-1:0];
                q_next   = {q_reg[RATE_W-2:0], div_ge};
                lo_next  = {lo_reg[RATE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RATE_W - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        d_reg   <= d_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done = (state_reg == MD_DONE);
    assign q    = q_reg;

endmodule

/* rtl/core/gfare_hist.sv */
// ============================================================================
// gfare_hist
// Shift history of window rate samples. After each push a single comparator
// sweeps the history one entry per cycle to find the maximum.
// ============================================================================
module gfare_hist #(
    parameter int HISTORY_DEPTH = gfare_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [gfare_pkg::RATE_W-1:0] rate,
    output logic                         done,
    output logic [gfare_pkg::RATE_W-1:0] rate_max,
    output logic [gfare_pkg::RATE_W-1:0] latest_rate
);
    import gfare_pkg::*;

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    logic [RATE_W-1:0] hist_reg [HISTORY_DEPTH];
    logic [RATE_W-1:0] hist_next [HISTORY_DEPTH];
    logic [RATE_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [RATE_W-1:0] sel;
    logic              sweep_end;

    assign sel       = hist_reg[cnt_reg[IDX_W-1:0]];
    assign sweep_end = (cnt_reg == CNT_W'(HISTORY_DEPTH));

    // Push shifts the history; the sweep then folds one entry per cycle.
    always_comb
    begin
        hist_next = hist_reg;
        max_next  = max_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (push)
        begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            begin
                hist_next[i] = hist_reg[i-1];
            end
            hist_next[0] = rate;
            max_next     = rate;
            cnt_next     = CNT_W'(1);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sweep_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (sel > max_reg)
                begin
                    max_next = sel;
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // History and running maximum start at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            max_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            hist_reg <= hist_next;
            max_reg  <= max_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign done        = busy_reg && sweep_end;
    assign rate_max    = max_reg;
    assign latest_rate = hist_reg[0];

endmodule

/* rtl/core/gap_filtered_ack_rate_estimator_unit.sv */
// ============================================================================
// gap_filtered_ack_rate_estimator_unit
// Sums acknowledged bytes over windows of at least one smoothed RTT, removes
// the longest acknowledgement gap, and reports the peak recent delivery rate.
// ============================================================================
// Usage:
//   ack_in carries one acknowledgement event per transfer (time stamp,
//   acknowledged bytes, smoothed RTT). rate_out returns exactly one report
//   per event: the history maximum, the newest sample and a window-closed
//   flag. The unit works on one event at a time; ack_in.ready is low while an
//   event is in progress.
//   Sequence: an event that does not close a window passes through the
//   window update and then loads its report into the output register,
//   after which the next event is taken. An event that closes a window
//   passes through the window update, the multiply/divide unit (two
//   partial products, recombine, overflow check, 64 one-bit division steps,
//   done), the maximum sweep over the history and the report load, after
//   which the next event follows. A saturated quotient skips the 64
//   division steps, and a zero span skips the unit.
//   The report sits in an output register, so the next event is taken while
//   it waits; if the receiver stalls, a second report waits in the final
//   state until the first one is transferred.
//   Reset clears the window, the byte counters, the history and the maximum.
// ============================================================================
module gap_filtered_ack_rate_estimator_unit #(
    parameter int HISTORY_DEPTH    = gfare_pkg::HISTORY_DEPTH_DEF,
    parameter int TICKS_PER_SECOND = gfare_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    gfare_ack_if.sink          ack_in,
    gfare_rate_if.source       rate_out
);
    import gfare_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GAP  = 7'b0000010,
        S_SPAN = 7'b0000100,
        S_NET  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_HIST = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   ts_reg, ts_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [RTT_W-1:0]    rtt_reg, rtt_next;
    logic [TIME_W-1:0]   ws_reg, ws_next;
    logic [TIME_W-1:0]   we_reg, we_next;
    logic [TIME_W-1:0]   lg_reg, lg_next;
    logic [RATE_W-1:0]   sum_reg, sum_next;
    logic [BYTES_W-1:0]  drop_reg, drop_next;
    logic [TIME_W-1:0]   span_reg, span_next;
    logic                closed_reg, closed_next;
    logic                out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]   out_max_reg, out_max_next;
    logic [RATE_W-1:0]   out_latest_reg, out_latest_next;
    logic                out_closed_reg, out_closed_next;

    logic                in_xfer;
    logic                out_free;
    logic                started;
    logic [TIME_W-1:0]   we_eff;
    logic [TIME_W-1:0]   gap;
    logic [TIME_W-1:0]   span;
    logic [TIME_W-1:0]   net;

    logic                md_start;
    logic [RATE_W-1:0]   md_a;
    logic [RATE_W-1:0]   md_d;
    logic                md_done;
    logic [RATE_W-1:0]   md_q;

    logic                hist_push;
    logic [RATE_W-1:0]   hist_rate;
    logic                hist_done;
    logic [RATE_W-1:0]   hist_max;
    logic [RATE_W-1:0]   hist_latest;

    assign in_xfer  = ack_in.valid && ack_in.ready;
    assign out_free = !out_valid_reg || rate_out.ready;

    // Window arithmetic for the current event.
    assign started = (ws_reg != '0);
    assign we_eff  = started ? we_reg : ts_reg;
    assign gap     = ts_reg - we_eff;
    assign span    = we_reg - ws_reg;
    assign net     = span_reg - lg_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        ts_next         = ts_reg;
        bytes_next      = bytes_reg;
        rtt_next        = rtt_reg;
        ws_next         = ws_reg;
        we_next         = we_reg;
        lg_next         = lg_reg;
        sum_next        = sum_reg;
        drop_next       = drop_reg;
        span_next       = span_reg;
        closed_next     = closed_reg;
        out_valid_next  = out_valid_reg && !rate_out.ready;
        out_max_next    = out_max_reg;
        out_latest_next = out_latest_reg;
        out_closed_next = out_closed_reg;
        md_start        = 1'b0;
        md_a            = sum_reg - RATE_W'(drop_reg);
        md_d            = net;
        hist_push       = 1'b0;
        hist_rate       = md_q;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    ts_next    = ack_in.ack_time;
                    bytes_next = ack_in.acked_bytes;
                    rtt_next   = ack_in.srtt;
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                // Open the window if needed, track the largest gap, add bytes.
                if (!started)
                begin
                    ws_next = ts_reg;
                end
                if (gap > lg_reg)
                begin
                    lg_next   = gap;
                    drop_next = bytes_reg;
                end
                sum_next   = sum_reg + RATE_W'(bytes_reg);
                we_next    = ts_reg;
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                span_next = span;
                if (span >= TIME_W'(rtt_reg))
                begin
                    closed_next = 1'b1;
                    state_next  = S_NET;
                end
                else
                begin
                    closed_next = 1'b0;
                    state_next  = S_DONE;
                end
            end
            S_NET:
            begin
                // Choose the sample formula and reset the window.
                if (net != '0)
                begin
                    md_start   = 1'b1;
                    state_next = S_DIV;
                end
                else if (span_reg != '0)
                begin
                    md_start   = 1'b1;
                    md_a       = sum_reg;
                    md_d       = span_reg;
                    state_next = S_DIV;
                end
                else
                begin
                    hist_push  = 1'b1;
                    hist_rate  = '0;
                    state_next = S_HIST;
                end
                sum_next  = '0;
                drop_next = '0;
                lg_next   = '0;
                ws_next   = we_reg;
            end
            S_DIV:
            begin
                if (md_done)
                begin
                    hist_push  = 1'b1;
                    state_next = S_HIST;
                end
            end
            S_HIST:
            begin
                if (hist_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the report to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_max_next    = hist_max;
                    out_latest_next = hist_latest;
                    out_closed_next = closed_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and window registers with a defined reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= '0;
            we_reg        <= '0;
            lg_reg        <= '0;
            sum_reg       <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            lg_reg        <= lg_next;
            sum_reg       <= sum_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ts_reg         <= ts_next;
        bytes_reg      <= bytes_next;
        rtt_reg        <= rtt_next;
        span_reg       <= span_next;
        closed_reg     <= closed_next;
        out_max_reg    <= out_max_next;
        out_latest_reg <= out_latest_next;
        out_closed_reg <= out_closed_next;
    end

    gfare_muldiv #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .d     (md_d),
        .done  (md_done),
        .q     (md_q)
    );

    gfare_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (hist_push),
        .rate        (hist_rate),
        .done        (hist_done),
        .rate_max    (hist_max),
        .latest_rate (hist_latest)
    );

    assign ack_in.ready           = (state_reg == S_IDLE);
    assign rate_out.valid         = out_valid_reg;
    assign rate_out.rate_max      = out_max_reg;
    assign rate_out.latest_rate   = out_latest_reg;
    assign rate_out.window_closed = out_closed_reg;

    // An accepted event always starts with the window update.
    a_accept_to_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_GAP))
        else $error("accepted event did not enter the window update");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    // A sample enters the history only for an event that closed a window.
    a_push_closed: assert property (@(posedge clk) disable iff (!rst_n)
        hist_push |-> closed_reg)
        else $error("history push without a closed window");

endmodule
